>>> rtl/tle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

    typedef enum logic [1:0] {
        CMD_RX      = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_TX      = 2'd3
    } tle_cmd_t;

    typedef enum logic [2:0] {
        SEQ_SINGLE = 3'd0,
        SEQ_PROMPT = 3'd1,
        SEQ_ERASE  = 3'd2,
        SEQ_CRLF   = 3'd3,
        SEQ_READ   = 3'd4
    } tle_seq_t;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_PROMPT = 8'h3E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        tle_seq_t   seq;
        logic       kind;
        logic [7:0] data;
        logic       grant;
        logic       ready_flag;
        logic [6:0] length_now;
    } tle_job_t;

    function automatic logic [2:0] seq_count(input tle_seq_t seq);
        logic [2:0] n;
        unique case (seq)
            SEQ_PROMPT: n = 3'd5;
            SEQ_ERASE:  n = 3'd3;
            SEQ_CRLF:   n = 3'd2;
            SEQ_SINGLE: n = 3'd1;
            SEQ_READ:   n = 3'd1;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] seq_byte(input tle_seq_t seq, input logic [2:0] step,
                                            input logic [7:0] data, input logic grant,
                                            input logic [7:0] rd);
        logic [7:0] b;
        unique case (seq)
            SEQ_PROMPT:
            begin
                unique case (step)
                    3'd0, 3'd1: b = CH_CR;
                    3'd2:       b = CH_LF;
                    3'd3:       b = CH_PROMPT;
                    default:    b = CH_SPACE;
                endcase
            end
            SEQ_ERASE:  b = (step == 3'd1) ? CH_SPACE : CH_BS;
            SEQ_CRLF:   b = (step == 3'd0) ? CH_CR : CH_LF;
            SEQ_SINGLE: b = data;
            SEQ_READ:   b = grant ? rd : CH_NUL;
            default:    b = data;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tle_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tle_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [6:0] read_index;

    modport source (output valid, output command, output data_byte, output read_index,
                    input ready);
    modport sink (input valid, input command, input data_byte, input read_index,
                  output ready);
endinterface

interface tle_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       last;
    logic       ready_flag;
    logic [6:0] length_now;

    modport source (output valid, output out_kind, output out_byte, output last,
                    output ready_flag, output length_now, input ready);
    modport sink (input valid, input out_kind, input out_byte, input last,
                  input ready_flag, input length_now, output ready);
endinterface

`default_nettype wire

>>> rtl/terminal_line_editor_echo_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Line editor with echo for a serial console.
// Channel cmd takes requests: command 0 received byte, 1 read line byte at
// read_index, 2 release line, 3 host transmit byte. Channel res returns the
// results: echo and transmit bytes (out_kind 0) and line read data
// (out_kind 1), with last marking the final result of a request and the
// line state after that request in ready_flag and length_now.
// The line is kept in a LINE_SIZE x 8 synchronous memory; length and the
// ready flag sit in registers next to it. A request is decoded, the state
// updated and the memory accessed in the cycle it is accepted; results then
// leave through a sequencer and an output register.
// Results per request: 1 to 5 (empty-line CR/LF gives 5, erase 3, host LF
// 2), or none; the sequencer emits one byte per cycle while res is not
// stalled, and takes the next request with results as it emits the last
// byte of the previous one.
// Reset clears length, ready flag and all pending results; the line memory
// is not cleared. When res stalls, the output register holds and cmd.ready
// drops once the sequencer has a request waiting behind it.
module terminal_line_editor_echo_unit #(
    parameter int LINE_SIZE = 128
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tle_in_if.sink    cmd,
    tle_out_if.source res
);

    import tle_pkg::*;

    localparam int AW = $clog2(LINE_SIZE);
    localparam int IW = (AW > 7) ? AW : 7;

    logic [AW-1:0] length_reg;
    logic [AW-1:0] length_next;
    logic          ready_reg;
    logic          ready_next;

    logic          accept;
    logic          job_free;
    logic          has_res;
    logic          wr_en;
    logic          rd_en;
    logic          grant;
    tle_seq_t      seq;
    tle_job_t      job;
    logic [7:0]    rd_data;
    logic [7:0]    b;
    logic [IW-1:0] idx_ext;

    assign accept  = cmd.valid && cmd.ready;
    assign b       = cmd.data_byte;
    assign idx_ext = IW'(cmd.read_index);
    assign grant   = ready_reg && (idx_ext < IW'(length_reg));

    always_comb
    begin
        has_res     = 1'b0;
        seq         = SEQ_SINGLE;
        length_next = length_reg;
        ready_next  = ready_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        unique case (tle_cmd_t'(cmd.command))
            CMD_RX:
            begin
                if (!ready_reg)
                begin
                    if (b == CH_CR || b == CH_LF)
                    begin
                        if (length_reg != '0)
                        begin
                            ready_next = 1'b1;
                        end
                        else
                        begin
                            has_res = 1'b1;
                            seq     = SEQ_PROMPT;
                        end
                    end
                    else if (b == CH_BS || b == CH_DEL)
                    begin
                        if (length_reg != '0)
                        begin
                            length_next = length_reg - AW'(1);
                            has_res     = 1'b1;
                            seq         = SEQ_ERASE;
                        end
                    end
                    else if (b >= CH_SPACE && b <= CH_TILDE
                             && length_reg < AW'(LINE_SIZE - 1))
                    begin
                        wr_en       = accept;
                        length_next = length_reg + AW'(1);
                        has_res     = 1'b1;
                        seq         = SEQ_SINGLE;
                    end
                end
            end
            CMD_READ:
            begin
                has_res = 1'b1;
                seq     = SEQ_READ;
                rd_en   = accept && grant;
            end
            CMD_RELEASE:
            begin
                if (ready_reg)
                begin
                    ready_next  = 1'b0;
                    length_next = '0;
                end
            end
            CMD_TX:
            begin
                has_res = 1'b1;
                seq     = (b == CH_LF) ? SEQ_CRLF : SEQ_SINGLE;
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        job.seq        = seq;
        job.kind       = (seq == SEQ_READ);
        job.data       = b;
        job.grant      = grant;
        job.ready_flag = ready_next;
        job.length_now = 7'(length_next);
    end

    assign cmd.ready = job_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            ready_reg  <= 1'b0;
        end
        else if (accept)
        begin
            length_reg <= length_next;
            ready_reg  <= ready_next;
        end
    end

    // writes only happen with no line ready and reads only with one ready,
    // so a read never meets a write to the same entry still in flight
    tle_line_mem #(
        .DEPTH (LINE_SIZE),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (length_reg),
        .wr_data (b),
        .rd_en   (rd_en),
        .rd_addr (idx_ext[AW-1:0]),
        .rd_data (rd_data)
    );

    tle_emitter u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_load (accept && has_res),
        .job      (job),
        .rd_data  (rd_data),
        .job_free (job_free),
        .res      (res)
    );

`ifndef SYNTHESIS
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        IW'(length_reg) < IW'(LINE_SIZE - 1) || IW'(length_reg) == IW'(LINE_SIZE - 1))
        else $error("line length beyond store size");

    a_ready_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (length_reg != '0))
        else $error("line ready with empty line");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.command == CMD_RELEASE && ready_reg)
        |=> (!ready_reg && length_reg == '0))
        else $error("release did not clear the line");
`endif

endmodule

`default_nettype wire

>>> rtl/tle_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module tle_line_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/tle_emitter.sv
`timescale 1ns / 1ps
`default_nettype none

module tle_emitter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_load,
    input  wire tle_pkg::tle_job_t job,
    input  wire logic [7:0]        rd_data,
    output logic                   job_free,
    tle_out_if.source              res
);

    import tle_pkg::*;

    tle_job_t   job_reg;
    logic       job_valid_reg;
    logic [2:0] step_reg;
    logic       out_valid_reg;
    logic       out_kind_reg;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       ready_flag_reg;
    logic [6:0] length_now_reg;

    logic       load_ok;
    logic       emit;
    logic       final_step;
    logic       job_done;
    logic [7:0] byte_next;

    assign load_ok    = !out_valid_reg || res.ready;
    assign emit       = job_valid_reg && load_ok;
    assign final_step = (step_reg == (seq_count(job_reg.seq) - 3'd1));
    assign job_done   = emit && final_step;
    assign job_free   = !job_valid_reg || job_done;
    assign byte_next  = seq_byte(job_reg.seq, step_reg, job_reg.data, job_reg.grant, rd_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_load)
            begin
                job_valid_reg <= 1'b1;
                step_reg      <= 3'd0;
            end
            else if (job_done)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                step_reg <= step_reg + 3'd1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
        if (emit)
        begin
            out_kind_reg   <= job_reg.kind;
            out_byte_reg   <= byte_next;
            last_reg       <= final_step;
            ready_flag_reg <= job_reg.ready_flag;
            length_now_reg <= job_reg.length_now;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.out_kind   = out_kind_reg;
    assign res.out_byte   = out_byte_reg;
    assign res.last       = last_reg;
    assign res.ready_flag = ready_flag_reg;
    assign res.length_now = length_now_reg;

`ifndef SYNTHESIS
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (step_reg < seq_count(job_reg.seq)))
        else $error("emitter step beyond sequence length");

    a_denied_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && job_reg.seq == SEQ_READ && !job_reg.grant) |=> (res.out_byte == CH_NUL))
        else $error("denied line read returned nonzero byte");
`endif

endmodule

`default_nettype wire

>>> sim/terminal_line_editor_echo_checker.sv
`timescale 1ns / 1ps

module terminal_line_editor_echo_checker
    import tle_pkg::*;
#(
    parameter int LINE_SIZE = 128
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tle_in_if         req_bus,
    tle_out_if        res_bus,
    output int        mismatch_count,
    output int        outstanding
);

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       last;
        logic       ready_flag;
        logic [6:0] length_now;
    } line_result_t;

    logic [7:0]   line_mem [LINE_SIZE];
    logic [6:0]   line_len;
    logic         line_ready;
    line_result_t awaited_results [$];

    function automatic void report_failure(input string what, input line_result_t want,
                                           input line_result_t got);
        if (mismatch_count < 10)
            $display("%0t %s: expected kind=%0d byte=%02h last=%0d ready=%0d len=%0d,",
                     $time, what, want.out_kind, want.out_byte, want.last, want.ready_flag,
                     want.length_now,
                     " got kind=%0d byte=%02h last=%0d ready=%0d len=%0d",
                     got.out_kind, got.out_byte, got.last, got.ready_flag, got.length_now);
        mismatch_count++;
    endfunction

    // Apply one request to the line state and queue the bytes it sends back.
    task automatic edit_line(input tle_cmd_t op, input logic [7:0] data,
                             input logic [6:0] idx);
        logic [7:0]   echo [5];
        logic         kind;
        int           n;
        line_result_t r;
        n = 0;
        kind = 1'b0;
        case (op)
            CMD_RX:
            begin
                if (!line_ready)
                begin
                    if (data == CH_CR || data == CH_LF)
                    begin
                        if (line_len != 7'd0)
                            line_ready = 1'b1;
                        else
                        begin
                            echo[0] = CH_CR;
                            echo[1] = CH_CR;
                            echo[2] = CH_LF;
                            echo[3] = CH_PROMPT;
                            echo[4] = CH_SPACE;
                            n = 5;
                        end
                    end
                    else if (data == CH_BS || data == CH_DEL)
                    begin
                        if (line_len != 7'd0)
                        begin
                            line_len = line_len - 7'd1;
                            echo[0] = CH_BS;
                            echo[1] = CH_SPACE;
                            echo[2] = CH_BS;
                            n = 3;
                        end
                    end
                    else if (data >= CH_SPACE && data <= CH_TILDE
                             && int'(line_len) < LINE_SIZE - 1)
                    begin
                        line_mem[line_len] = data;
                        line_len = line_len + 7'd1;
                        echo[0] = data;
                        n = 1;
                    end
                end
            end
            CMD_READ:
            begin
                kind = 1'b1;
                echo[0] = (line_ready && idx < line_len) ? line_mem[idx] : CH_NUL;
                n = 1;
            end
            CMD_RELEASE:
            begin
                if (line_ready)
                begin
                    line_ready = 1'b0;
                    line_len = 7'd0;
                end
            end
            default:
            begin
                if (data == CH_LF)
                begin
                    echo[0] = CH_CR;
                    echo[1] = CH_LF;
                    n = 2;
                end
                else
                begin
                    echo[0] = data;
                    n = 1;
                end
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            r.out_kind = kind;
            r.out_byte = echo[i];
            r.last = (i == n - 1);
            r.ready_flag = line_ready;
            r.length_now = line_len;
            awaited_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t want;
        line_result_t got;
        if (!rst_n)
        begin
            line_len = 7'd0;
            line_ready = 1'b0;
            awaited_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                got = {res_bus.out_kind, res_bus.out_byte, res_bus.last,
                       res_bus.ready_flag, res_bus.length_now};
                if (awaited_results.size() == 0)
                    report_failure("result with nothing pending", '0, got);
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte
                        || got.last !== want.last || got.ready_flag !== want.ready_flag
                        || got.length_now !== want.length_now)
                        report_failure("result mismatch", want, got);
                end
            end
            if (req_bus.valid && req_bus.ready)
                edit_line(tle_cmd_t'(req_bus.command), req_bus.data_byte, req_bus.read_index);
            outstanding = awaited_results.size();
        end
    end

    initial
    begin
        mismatch_count = 0;
        outstanding = 0;
        line_len = 7'd0;
        line_ready = 1'b0;
        for (int i = 0; i < LINE_SIZE; i++)
            line_mem[i] = CH_NUL;
    end

endmodule

>>> sim/terminal_line_editor_echo_unit_test.sv
`timescale 1ns / 1ps

module terminal_line_editor_echo_unit_test;
    import tle_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_request;
    bit   hold_off;
    int   items_sent;
    int   mismatch_count;
    int   outstanding;
    int unsigned cycle_count;

    tle_in_if  cmd_bus ();
    tle_out_if res_bus ();

    terminal_line_editor_echo_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    terminal_line_editor_echo_checker line_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_bus        (cmd_bus),
        .res_bus        (res_bus),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[terminal_line_editor_echo_unit] ERROR");
        $finish;
    end

    // Hold the result channel off for a long stretch on demand.
    initial
    begin
        hold_off = 1'b0;
        forever
        begin
            wait (hold_request);
            hold_request = 1'b0;
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off = 1'b0;
        end
    end

    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_bus.ready = !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input tle_cmd_t op, input logic [7:0] data,
                                input logic [6:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_bus.valid = 1'b0;
            cmd_bus.command = 2'($urandom);
            cmd_bus.data_byte = 8'($urandom);
            cmd_bus.read_index = 7'($urandom);
        end
        @(negedge clk);
        cmd_bus.valid = 1'b1;
        cmd_bus.command = op;
        cmd_bus.data_byte = data;
        cmd_bus.read_index = idx;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every pending result has come back.
    task automatic wait_drained();
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic send_line_session();
        int         len;
        logic [7:0] ch;
        len = 0;
        repeat ($urandom_range(0, 12))
        begin
            if ($urandom_range(99) < 15)
            begin
                ch = $urandom_range(1) ? CH_BS : CH_DEL;
                if (len > 0)
                    len--;
            end
            else
            begin
                ch = 8'($urandom_range(32, 126));
                len++;
            end
            send_request(CMD_RX, ch, 7'($urandom));
        end
        send_request(CMD_RX, $urandom_range(1) ? CH_CR : CH_LF, 7'($urandom));
        repeat ($urandom_range(1, 4))
            send_request(CMD_READ, 8'($urandom), 7'($urandom_range(0, len + 2)));
        if ($urandom_range(3) == 0)
            send_request(CMD_RX, 8'($urandom), 7'($urandom));
        if ($urandom_range(3) == 0)
            send_request(CMD_TX, $urandom_range(1) ? CH_LF : 8'($urandom), 7'($urandom));
        send_request(CMD_RELEASE, 8'($urandom), 7'($urandom));
    endtask

    task automatic send_mixed_traffic(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 70)
                send_line_session();
            else
                send_request(tle_cmd_t'($urandom_range(3)), 8'($urandom), 7'($urandom));
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        send_mixed_traffic(count);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_RX;
        cmd_bus.data_byte = 8'd0;
        cmd_bus.read_index = 7'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        items_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty-line terminators, erase on empty, character range edges.
        send_request(CMD_RX, CH_CR, 7'd0);
        send_request(CMD_RX, CH_LF, 7'd127);
        send_request(CMD_RX, CH_BS, 7'd0);
        send_request(CMD_RX, CH_DEL, 7'd0);
        send_request(CMD_RX, CH_SPACE, 7'd0);
        send_request(CMD_RX, CH_TILDE, 7'd0);
        send_request(CMD_RX, 8'h1F, 7'd0);
        send_request(CMD_RX, CH_DEL, 7'd0);
        send_request(CMD_RX, 8'h80, 7'd0);
        send_request(CMD_RX, 8'hFF, 7'd0);
        send_request(CMD_RX, 8'h41, 7'd0);
        send_request(CMD_READ, 8'h00, 7'd0);
        send_request(CMD_RX, CH_CR, 7'd0);
        // Ignore received bytes while the line is ready.
        send_request(CMD_RX, 8'h5A, 7'd0);
        send_request(CMD_RX, CH_BS, 7'd0);
        send_request(CMD_READ, 8'hFF, 7'd0);
        send_request(CMD_READ, 8'h00, 7'd1);
        send_request(CMD_READ, 8'h00, 7'd2);
        send_request(CMD_READ, 8'h00, 7'd127);
        send_request(CMD_RELEASE, 8'h00, 7'd0);
        send_request(CMD_RELEASE, 8'h00, 7'd0);
        send_request(CMD_TX, CH_LF, 7'd0);
        send_request(CMD_TX, 8'h00, 7'd0);
        send_request(CMD_TX, 8'hFF, 7'd0);
        send_request(CMD_TX, CH_CR, 7'd0);
        wait_drained();

        run_phase(0, 0, 10);
        run_phase(66, 0, 10);
        run_phase(0, 66, 10);
        run_phase(38, 38, 10);

        // Build a longer line with an erase, then read around its end.
        send_idle_pct = 10;
        recv_stall_pct = 20;
        repeat (9)
            send_request(CMD_RX, 8'($urandom_range(32, 126)), 7'($urandom));
        send_request(CMD_RX, CH_BS, 7'd0);
        send_request(CMD_RX, CH_LF, 7'd0);
        send_request(CMD_READ, 8'h00, 7'd7);
        send_request(CMD_READ, 8'h00, 7'd8);
        send_request(CMD_RELEASE, 8'h00, 7'd0);
        wait_drained();

        // Keep offering prompt-heavy requests while results are held off.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b1;
        repeat (6)
        begin
            send_request(CMD_RX, CH_CR, 7'($urandom));
            send_request(CMD_TX, CH_LF, 7'($urandom));
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("[terminal_line_editor_echo_unit] OK");
        else
            $display("[terminal_line_editor_echo_unit] ERROR");
        $finish;
    end

endmodule
